### rtl/psq_pkg.sv
// psq_pkg: shared types, constants and codes for the pooled sorted queue engine
// no dependencies

package psq_pkg;

  localparam int POOL_NODES_DEF = 64;
  localparam int NUM_QUEUES_DEF = 8;
  localparam int MODE_W = 2;
  localparam int QID_W = 3;
  localparam int DATA_W = 32;
  localparam int KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int MASK_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_REMOVE_LE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NONE = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  localparam logic [0:0] REG_ORDERED_MASK = 1'b0;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD_FREE,
    S_POP_FREE,
    S_RD_HEAD,
    S_WALK,
    S_LINK,
    S_DONE
  } state_t;

endpackage

### rtl/psq_ram.sv
// psq_ram: generic single-port-write, single-read RAM with registered read
// no dependencies

module psq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pooled_sorted_queue_engine_top.sv
// pooled_sorted_queue_engine_top: linked queues in a shared node pool with a free list
// depends on psq_pkg and psq_ram
//
// channel  | handshake           | payload
// input    | in_valid / in_stall | mode, queue_id, item_data, key
// output   | out_valid/out_stall | status, out_data, out_key
// config   | apb psel/penable    | ordered_mask at byte address 0
//
// after reset a clearing pass over all POOL_NODES nodes builds the free chain, input stalled
// mode 3 or a queue out of range goes straight to the result, a remove reads the queue
// head first, an insert reads and pops the free list (a refused one stops after the read)
// and then links the node; an ordered insert also walks one node per compared key (one
// memory read each), up to POOL_NODES
// one item at a time; a finished item waits in the output register and the
// next item is taken once that register is free

module pooled_sorted_queue_engine_top
  import psq_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [QID_W-1:0]    queue_id,
  input  logic [DATA_W-1:0]   item_data,
  input  logic [KEY_W-1:0]    key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   out_data,
  output logic [KEY_W-1:0]    out_key,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(POOL_NODES);
  localparam int PW = AW + 1;          // pointer with null code
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

  // config register
  logic [MASK_W-1:0] ordered_mask;
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {{(32-MASK_W){1'b0}}, ordered_mask} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      ordered_mask <= '0;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
      ordered_mask <= pwdata[MASK_W-1:0];
    end
  end

  // queue head/tail and free head in flops (small arrays, fixed ports)
  logic [PW-1:0] qhead [NUM_QUEUES];
  logic [PW-1:0] qtail [NUM_QUEUES];
  logic [PW-1:0] free_head;

  // node memories
  logic          nx_we, kd_we;
  logic [AW-1:0] nx_waddr, nx_raddr, kd_waddr, kd_raddr;
  logic [PW-1:0] nx_wdata, nx_rdata;
  logic [DATA_W+KEY_W-1:0] kd_wdata, kd_rdata;

  psq_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));

  psq_ram #(.WIDTH(DATA_W+KEY_W), .DEPTH(POOL_NODES)) u_node (
    .clk(clk), .we(kd_we), .waddr(kd_waddr), .wdata(kd_wdata),
    .raddr(kd_raddr), .rdata(kd_rdata));

  state_t state, state_next;

  // captured item
  logic [MODE_W-1:0] op_mode;
  logic [QW-1:0]     op_q;
  logic [DATA_W-1:0] op_data;
  logic [KEY_W-1:0]  op_key;
  logic              op_ord;
  logic              op_qok;
  logic [PW-1:0]     new_node;
  logic [PW-1:0]     prev, curr;
  logic [AW:0]       steps;
  logic [AW-1:0]     init_cnt;

  logic              res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0] res_data;
  logic [KEY_W-1:0]  res_key;

  assign out_valid = res_valid;
  assign status = res_status;
  assign out_data = res_data;
  assign out_key = res_key;
  assign in_stall = (state != S_IDLE) || res_valid;

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = res_valid && !out_stall;

  logic q_ok;
  assign q_ok = ({{(32-QID_W){1'b0}}, queue_id} < 32'(NUM_QUEUES));

  // walk continue test, read data of curr is in nx_rdata/kd_rdata
  logic walk_go;
  assign walk_go = (curr != NIL) && (kd_rdata[KEY_W-1:0] <= op_key) &&
                   (steps < (AW+1)'(POOL_NODES));

  // remove decision in S_DONE, head node read data in nx_rdata/kd_rdata
  logic rm_ok;
  assign rm_ok = (op_mode == MODE_REMOVE || op_mode == MODE_REMOVE_LE) && op_qok &&
                 (curr != NIL) &&
                 !(op_mode == MODE_REMOVE_LE && kd_rdata[KEY_W-1:0] > op_key);

  always_comb begin
    state_next = state;
    nx_we = 1'b0;
    nx_waddr = '0;
    nx_wdata = '0;
    nx_raddr = '0;
    kd_we = 1'b0;
    kd_waddr = '0;
    kd_wdata = '0;
    kd_raddr = '0;
    case (state)
      S_INIT: begin
        nx_we = 1'b1;
        nx_waddr = init_cnt;
        nx_wdata = (init_cnt == AW'(POOL_NODES-1)) ? NIL : PW'(init_cnt) + PW'(1);
        if (init_cnt == AW'(POOL_NODES-1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (!q_ok || mode == MODE_UNUSED) begin
            state_next = S_DONE;
          end else if (mode == MODE_INSERT) begin
            state_next = S_RD_FREE;
          end else begin
            state_next = S_RD_HEAD;
          end
        end
      end
      S_RD_FREE: begin
        // read next of free head
        nx_raddr = free_head[AW-1:0];
        if (free_head == NIL) begin
          state_next = S_DONE;
        end else begin
          state_next = S_POP_FREE;
        end
      end
      S_POP_FREE: begin
        // free list pops now; ordered insert starts reading the queue head
        nx_raddr = curr[AW-1:0];
        kd_raddr = curr[AW-1:0];
        if (op_ord && curr != NIL) begin
          state_next = S_WALK;
        end else begin
          state_next = S_LINK;
        end
      end
      S_RD_HEAD: begin
        nx_raddr = qhead[op_q][AW-1:0];
        kd_raddr = qhead[op_q][AW-1:0];
        state_next = S_DONE;
      end
      S_WALK: begin
        // curr's data is in kd_rdata / nx_rdata; fetch the following node
        nx_raddr = nx_rdata[AW-1:0];
        kd_raddr = nx_rdata[AW-1:0];
        if (!walk_go || nx_rdata == NIL) state_next = S_LINK;
      end
      S_LINK: begin
        nx_we = 1'b1;
        nx_waddr = new_node[AW-1:0];
        nx_wdata = curr;
        kd_we = 1'b1;
        kd_waddr = new_node[AW-1:0];
        kd_wdata = {op_data, op_ord ? op_key : {KEY_W{1'b0}}};
        state_next = S_DONE;
      end
      S_DONE: begin
        // remove: write back node next to free list
        if (rm_ok) begin
          nx_we = 1'b1;
          nx_waddr = curr[AW-1:0];
          nx_wdata = free_head;
        end else if (op_mode == MODE_INSERT && res_status == ST_OK && prev != NIL) begin
          nx_we = 1'b1;
          nx_waddr = prev[AW-1:0];
          nx_wdata = new_node;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      free_head <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qhead[i] <= NIL;
        qtail[i] <= NIL;
      end
    end else begin
      state <= state_next;
      if (out_acc) res_valid <= 1'b0;
      case (state)
        S_INIT: init_cnt <= init_cnt + AW'(1);
        S_IDLE: begin
          if (in_acc) begin
            op_mode <= mode;
            op_q <= QW'(queue_id);
            op_data <= item_data;
            op_key <= key;
            op_ord <= ordered_mask[queue_id];
            op_qok <= q_ok;
            res_status <= ST_NONE;
            res_data <= '0;
            res_key <= '0;
          end
        end
        S_RD_FREE: begin
          new_node <= free_head;
          steps <= '0;
          if (op_ord) begin
            curr <= qhead[op_q];
            prev <= NIL;
          end else begin
            curr <= NIL;
            prev <= qtail[op_q];
          end
          if (free_head == NIL) begin
            res_status <= ST_NO_FREE;
          end
        end
        S_POP_FREE: begin
          // nx_rdata is next of new node
          free_head <= nx_rdata;
        end
        S_RD_HEAD: begin
          curr <= qhead[op_q];
        end
        S_WALK: begin
          if (walk_go) begin
            prev <= curr;
            curr <= nx_rdata;
            steps <= steps + (AW+1)'(1);
          end
        end
        S_LINK: begin
          res_status <= ST_OK;
          if (prev == NIL) qhead[op_q] <= new_node;
          if (curr == NIL) qtail[op_q] <= new_node;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          if (rm_ok) begin
            res_status <= ST_OK;
            res_data <= kd_rdata[DATA_W+KEY_W-1:KEY_W];
            res_key <= kd_rdata[KEY_W-1:0];
            qhead[op_q] <= nx_rdata;
            if (nx_rdata == NIL) qtail[op_q] <= NIL;
            free_head <= curr;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/psq_checker.sv
// psq_checker: port-level assertions for the pooled sorted queue engine
// depends on psq_pkg; bound to pooled_sorted_queue_engine_top

module psq_checker
  import psq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [DATA_W-1:0]   out_data,
  input logic [KEY_W-1:0]    out_key
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_data) &&
    $stable(out_key))
    else $error("stalled result changed");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != ST_RSVD)
    else $error("reserved status");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_data == '0 && out_key == '0)
    else $error("payload not zero on failure");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

endmodule

bind pooled_sorted_queue_engine_top psq_checker u_psq_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .out_data(out_data), .out_key(out_key));

### tb/tb_pooled_sorted_queue_engine_top.sv
// testbench for pooled_sorted_queue_engine_top: directed table then random traffic,
// each result checked against an in-bench model of the pool, free list and queues
// depends on psq_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_pooled_sorted_queue_engine_top;
  import psq_pkg::*;

  localparam int NODES = POOL_NODES_DEF;
  localparam int QUEUES = NUM_QUEUES_DEF;
  localparam int NIL = NODES;
  localparam int RANDOM_ITEMS = 1290;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   data;
    logic [KEY_W-1:0]    k;
  } result_t;

  typedef struct {
    mode_t             op;
    logic [QID_W-1:0]  qid;
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  k;
    logic              typed;   // expected result given in the row
    result_t           want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [QID_W-1:0] queue_id = '0;
  logic [DATA_W-1:0] item_data = '0;
  logic [KEY_W-1:0] key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0] out_data;
  logic [KEY_W-1:0] out_key;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pooled_sorted_queue_engine_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .queue_id(queue_id), .item_data(item_data), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_data(out_data), .out_key(out_key),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the engine state
  logic [MASK_W-1:0] mask_shadow;
  logic [KEY_W-1:0]  pool_key [NODES];
  logic [DATA_W-1:0] pool_data [NODES];
  int                pool_next [NODES];
  int                free_top;
  int                qhead [QUEUES];
  int                qtail [QUEUES];
  int                live_count;

  result_t pending_results[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  exhausted_seen = 0;
  int  ordered_walks = 0;
  longint cycle_count = 0;
  bit  quiet_out = 1'b0;   // turn off random output stalls for a stretch

  function automatic void clear_pool_model();
    for (int i = 0; i < NODES; i++) begin
      pool_key[i] = '0;
      pool_data[i] = '0;
      pool_next[i] = i + 1;
    end
    free_top = 0;
    for (int i = 0; i < QUEUES; i++) begin
      qhead[i] = NIL;
      qtail[i] = NIL;
    end
    mask_shadow = '0;
    live_count = 0;
  endfunction

  // one accepted item in, one result out; updates the shadow state
  function automatic result_t apply_queue_op(mode_t op, int q, logic [DATA_W-1:0] d,
                                             logic [KEY_W-1:0] k);
    result_t r;
    int n, prev, curr, steps, h;
    r = '{st: ST_NONE, data: '0, k: '0};
    if (q >= QUEUES || op == MODE_UNUSED) return r;
    if (op == MODE_INSERT) begin
      n = free_top;
      if (n >= NODES) begin
        r.st = ST_NO_FREE;
        return r;
      end
      free_top = pool_next[n];
      pool_data[n] = d;
      pool_key[n] = '0;
      prev = NIL;
      curr = NIL;
      if (mask_shadow[q]) begin
        pool_key[n] = k;
        curr = qhead[q];
        steps = 0;
        while (curr < NODES && pool_key[curr] <= k && steps < NODES) begin
          prev = curr;
          curr = pool_next[curr];
          steps++;
        end
        if (curr >= NODES) curr = NIL;
        ordered_walks++;
      end else begin
        prev = qtail[q];
      end
      pool_next[n] = curr;
      if (prev < NODES) pool_next[prev] = n;
      else qhead[q] = n;
      if (curr >= NODES) qtail[q] = n;
      live_count++;
      r.st = ST_OK;
      return r;
    end
    h = qhead[q];
    if (h >= NODES || (op == MODE_REMOVE_LE && pool_key[h] > k)) return r;
    qhead[q] = pool_next[h];
    if (qhead[q] >= NODES) begin
      qhead[q] = NIL;
      qtail[q] = NIL;
    end
    pool_next[h] = free_top;
    free_top = h;
    live_count--;
    r = '{st: ST_OK, data: pool_data[h], k: pool_key[h]};
    return r;
  endfunction

  // output side: random stall, compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting: status %0d", status);
          mismatches++;
        end else begin
          result_t w;
          w = pending_results.pop_front();
          if (status !== w.st) begin
            $error("status: expected %0d, actual %0d", w.st, status);
            mismatches++;
          end
          if (out_data !== w.data) begin
            $error("out_data: expected %h, actual %h", w.data, out_data);
            mismatches++;
          end
          if (out_key !== w.k) begin
            $error("out_key: expected %h, actual %h", w.k, out_key);
            mismatches++;
          end
        end
      end
      out_stall <= quiet_out ? 1'b0 : ($urandom_range(0, 99) < 25);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_mask(logic [MASK_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ORDERED_MASK, 1'b0} << 1;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mask_shadow = value;
  endtask

  // drops valid, waits for every expected result, then a quiet spell
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NODES + 20) @(posedge clk);
  endtask

  // send one item; gap_pct is the chance of an idle cycle before it
  // valid stays high after the accepting edge until the next item or a drain
  task automatic send_item(mode_t op, logic [QID_W-1:0] q, logic [DATA_W-1:0] d,
                           logic [KEY_W-1:0] k, int gap_pct, bit typed, result_t want);
    result_t got;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    queue_id <= q;
    item_data <= d;
    key <= k;
    do @(posedge clk); while (in_stall);
    got = apply_queue_op(op, q, d, k);
    if (typed && got !== want) begin
      $error("directed row: expected %p, model gives %p", want, got);
      mismatches++;
    end
    pending_results.push_back(got);
  endtask

  function automatic row_t mk(mode_t op, int q, logic [31:0] d, logic [31:0] k,
                              bit typed = 0, int st = 0, logic [31:0] wd = 0,
                              logic [31:0] wk = 0);
    row_t r;
    r.op = op;
    r.qid = q[QID_W-1:0];
    r.data = d;
    r.k = k;
    r.typed = typed;
    r.want = '{st: st[1:0], data: wd, k: wk};
    return r;
  endfunction

  row_t directed[$];

  initial begin
    mode_t op;
    int q, sel;
    logic [KEY_W-1:0] k;
    logic [MASK_W-1:0] masks [5];

    clear_pool_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fifo queues first: after reset, removes on empty queues, mode 3, inserts and removes
    directed.push_back(mk(MODE_REMOVE, 0, 0, 0, 1, ST_NONE));
    directed.push_back(mk(MODE_REMOVE_LE, 7, 0, 32'hffff_ffff, 1, ST_NONE));
    directed.push_back(mk(MODE_UNUSED, 3, 32'hffff_ffff, 32'hffff_ffff, 1, ST_NONE));
    directed.push_back(mk(MODE_INSERT, 0, 32'hffff_ffff, 32'hffff_ffff, 1, ST_OK));
    directed.push_back(mk(MODE_INSERT, 0, 32'h0, 32'h1234, 1, ST_OK));
    // fifo stores key zero, so a conditional remove with threshold zero succeeds
    directed.push_back(mk(MODE_REMOVE_LE, 0, 0, 0, 1, ST_OK, 32'hffff_ffff, 0));
    directed.push_back(mk(MODE_REMOVE, 0, 0, 0, 1, ST_OK, 0, 0));
    directed.push_back(mk(MODE_REMOVE, 0, 0, 0, 1, ST_NONE));
    foreach (directed[i])
      send_item(directed[i].op, directed[i].qid, directed[i].data, directed[i].k, 0,
                directed[i].typed, directed[i].want);
    drain_engine();

    // ordered queue 5: extremes, equal keys keep arrival order, threshold not met
    write_mask(8'hff);
    directed.delete();
    directed.push_back(mk(MODE_INSERT, 5, 32'hA, 32'hffff_ffff));
    directed.push_back(mk(MODE_INSERT, 5, 32'hB, 32'h0));
    directed.push_back(mk(MODE_INSERT, 5, 32'hC, 32'h10));
    directed.push_back(mk(MODE_INSERT, 5, 32'hD, 32'h10));
    directed.push_back(mk(MODE_REMOVE_LE, 5, 0, 0, 1, ST_OK, 32'hB, 0));
    directed.push_back(mk(MODE_REMOVE_LE, 5, 0, 32'hf, 1, ST_NONE));
    directed.push_back(mk(MODE_REMOVE, 5, 0, 0, 1, ST_OK, 32'hC, 32'h10));
    directed.push_back(mk(MODE_REMOVE, 5, 0, 0, 1, ST_OK, 32'hD, 32'h10));
    directed.push_back(mk(MODE_REMOVE_LE, 5, 0, 32'hfffffffe, 1, ST_NONE));
    directed.push_back(mk(MODE_REMOVE_LE, 5, 0, 32'hffffffff, 1, ST_OK, 32'hA,
                          32'hffff_ffff));
    foreach (directed[i])
      send_item(directed[i].op, directed[i].qid, directed[i].data, directed[i].k, 0,
                directed[i].typed, directed[i].want);
    drain_engine();

    // pool exhaustion on an ordered queue, then one more insert is refused
    for (int i = 0; i <= NODES; i++)
      send_item(MODE_INSERT, 2, $urandom, $urandom_range(0, 3), 10, 0, '0);
    drain_engine();
    // mask change while queue 2 holds nodes: fifo-drain it partly, then back to ordered
    write_mask(8'h00);
    for (int i = 0; i < 8; i++) send_item(MODE_REMOVE, 2, 0, 0, 10, 0, '0);
    for (int i = 0; i < 4; i++) send_item(MODE_INSERT, 2, $urandom, $urandom, 10, 0, '0);
    drain_engine();
    write_mask(8'h04);
    for (int i = 0; i < 4; i++) send_item(MODE_INSERT, 2, $urandom, $urandom_range(0, 4),
                                          10, 0, '0);
    while (live_count > 0) send_item(MODE_REMOVE, 2, 0, 0, 0, 0, '0);
    drain_engine();

    // random phases, mask cycles through several settings including extremes
    masks = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h00};
    for (int ph = 0; ph < 5; ph++) begin
      write_mask(ph == 4 ? MASK_W'($urandom) : masks[ph]);
      quiet_out = (ph == 2);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        // each item picks a random queue, key and operation: insert, remove, conditional remove or mode 3
        sel = $urandom_range(0, 99);
        q = $urandom_range(0, 7);
        k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
        if (sel < 45 && live_count < NODES + 2) op = MODE_INSERT;
        else if (sel < 70) op = MODE_REMOVE;
        else if (sel < 95) op = MODE_REMOVE_LE;
        else op = MODE_UNUSED;
        if (ph == 2 && i == 100) drain_engine();   // sender holds until all results are in
        send_item(op, q[QID_W-1:0], $urandom, k, (ph == 2) ? 0 : 25, 0, '0);
        if (live_count >= NODES) exhausted_seen++;
      end
      drain_engine();
    end

    // wait for remaining results and a tail of quiet cycles
    drain_engine();
    $display("covered %0d results, %0d ordered walks, %0d items with the pool full",
             results_seen, ordered_walks, exhausted_seen);
    $display("fifo and ordered queues, conditional removes, mode 3 and mask changes");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
